[design/msq_pkg.sv]
// Shared codes for the mode-select stack / queue / priority store.
`timescale 1ns / 1ps
`default_nettype none

package msq_pkg;

  // Removal discipline codes (code 3 acts as the stack)
  localparam logic [1:0] DISC_STACK = 2'd0;
  localparam logic [1:0] DISC_FIFO  = 2'd1;
  localparam logic [1:0] DISC_PRIO  = 2'd2;

  // Command codes
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

endpackage

`default_nettype wire

[design/msq_store.sv]
// Simple dual-port storage array: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module msq_store #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 48,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             wr_en_i,
  input  wire logic [AW-1:0]    wr_addr_i,
  input  wire logic [WIDTH-1:0] wr_data_i,
  input  wire logic [AW-1:0]    rd_addr_i,
  output logic      [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // read port, data in the cycle after the address
  always_ff @(posedge clk_i) begin
    rd_data_o <= mem_q[rd_addr_i];
  end

endmodule

`default_nettype wire

[design/mode_select_stack_queue_prio.sv]
// Top level: sequencer, shared priority comparator, counters and output register.
//
//   channel | direction | handshake                | payload
//   --------+-----------+--------------------------+-----------------------------------------
//   cfg     | in        | cfg_we_i                 | cfg_wdata_i (discipline)
//   in      | in        | in_valid_i / in_ready_o  | command_i, value_i, priority_req_i
//   out     | out       | out_valid_o / out_ready_i| removed_value_o, status_o, occupancy_o,
//           |           |                          | peak_occupancy_o, insert/remove_total_o
//
// Insert and rejected items go from idle straight to the done state; stack and FIFO
// removes pass through the read state first. A priority remove makes two passes:
// one pass of reads through the single read port to find the minimum with
// the shared comparator, then a read/write pass that shifts the later entries down.
// in_ready_o is high only while the sequencer is idle; a finished result waits in the
// output register, and the next result waits in the sequencer if that one is not taken.
// Reset clears pointers, counts and totals at once; the store needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module mode_select_stack_queue_prio #(
  parameter int CAPACITY      = 1024,
  parameter int VALUE_BITS    = 32,
  parameter int PRIORITY_BITS = 16,
  localparam int CW           = $clog2(CAPACITY + 1)
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [1:0]                      cfg_wdata_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic                            command_i,
  input  wire logic [VALUE_BITS-1:0]           value_i,
  input  wire logic signed [PRIORITY_BITS-1:0] priority_req_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic [VALUE_BITS-1:0]                removed_value_o,
  output logic [1:0]                           status_o,
  output logic [CW-1:0]                        occupancy_o,
  output logic [CW-1:0]                        peak_occupancy_o,
  output logic [31:0]                          insert_total_o,
  output logic [31:0]                          remove_total_o
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int MW = VALUE_BITS + PRIORITY_BITS;
  localparam logic [CW-1:0] CAP_C     = CW'(CAPACITY);
  localparam logic [AW-1:0] LAST_SLOT = AW'(CAPACITY - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_SCAN,
    S_SHIFT,
    S_DONE
  } state_e;

  state_e state_q, state_d;
  logic [1:0]    disc_q, disc_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] peak_q, peak_d;
  logic [AW-1:0] head_q, head_d;
  logic [AW-1:0] tail_q, tail_d;
  logic [31:0]   ins_tot_q, ins_tot_d;
  logic [31:0]   rem_tot_q, rem_tot_d;

  // scan / shift sequencing
  logic [CW-1:0] idx_q, idx_d;
  logic [AW-1:0] pidx_q, pidx_d;
  logic          pend_q, pend_d;
  logic [AW-1:0] best_idx_q, best_idx_d;
  logic signed [PRIORITY_BITS-1:0] best_pr_q, best_pr_d;
  logic [VALUE_BITS-1:0] best_val_q, best_val_d;

  // pending result
  logic [VALUE_BITS-1:0] res_val_q, res_val_d;
  logic [1:0]            res_st_q, res_st_d;

  // output register
  logic                  out_valid_q, out_valid_d;
  logic [VALUE_BITS-1:0] out_val_q, out_val_d;
  logic [1:0]            out_st_q, out_st_d;
  logic [CW-1:0]         out_occ_q, out_occ_d;
  logic [CW-1:0]         out_peak_q, out_peak_d;
  logic [31:0]           out_ins_q, out_ins_d;
  logic [31:0]           out_rem_q, out_rem_d;

  // store port signals
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [MW-1:0] wr_data;
  logic [AW-1:0] rd_addr;
  logic [MW-1:0] rd_data;

  logic [VALUE_BITS-1:0]           rd_val;
  logic signed [PRIORITY_BITS-1:0] rd_pr;
  logic                            accept;
  logic                            pr_less;
  logic [CW-1:0]                   count_inc, count_dec;
  logic [AW-1:0]                   ins_slot;

  function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] p);
    ring_next = (p == LAST_SLOT) ? '0 : p + AW'(1);
  endfunction

  msq_store #(
    .DEPTH (CAPACITY),
    .WIDTH (MW),
    .AW    (AW)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  assign rd_val    = rd_data[MW-1:PRIORITY_BITS];
  assign rd_pr     = signed'(rd_data[PRIORITY_BITS-1:0]);
  assign in_ready_o = (state_q == S_IDLE);
  assign accept    = in_valid_i && in_ready_o;
  assign count_inc = count_q + CW'(1);
  assign count_dec = count_q - CW'(1);
  assign ins_slot  = (disc_q == msq_pkg::DISC_FIFO) ? tail_q : count_q[AW-1:0];

  // shared comparator: strict less keeps ties on the earliest entry
  assign pr_less = rd_pr < best_pr_q;

  // sequencer next state
  always_comb begin
    state_d     = state_q;
    disc_d      = disc_q;
    count_d     = count_q;
    peak_d      = peak_q;
    head_d      = head_q;
    tail_d      = tail_q;
    ins_tot_d   = ins_tot_q;
    rem_tot_d   = rem_tot_q;
    idx_d       = idx_q;
    pidx_d      = pidx_q;
    pend_d      = pend_q;
    best_idx_d  = best_idx_q;
    best_pr_d   = best_pr_q;
    best_val_d  = best_val_q;
    res_val_d   = res_val_q;
    res_st_d    = res_st_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_val_d   = out_val_q;
    out_st_d    = out_st_q;
    out_occ_d   = out_occ_q;
    out_peak_d  = out_peak_q;
    out_ins_d   = out_ins_q;
    out_rem_d   = out_rem_q;
    wr_en       = 1'b0;
    wr_addr     = ins_slot;
    wr_data     = {value_i, priority_req_i};
    rd_addr     = (disc_q == msq_pkg::DISC_FIFO) ? head_q : count_dec[AW-1:0];

    if (cfg_we_i) begin
      disc_d = cfg_wdata_i;
    end

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          res_val_d = '0;
          res_st_d  = msq_pkg::ST_OK;
          state_d   = S_DONE;
          if (command_i == msq_pkg::CMD_INSERT) begin
            if (count_q == CAP_C) begin
              res_st_d = msq_pkg::ST_FULL;
            end else begin
              wr_en     = 1'b1;
              count_d   = count_inc;
              ins_tot_d = ins_tot_q + 32'd1;
              if (count_inc > peak_q) begin
                peak_d = count_inc;
              end
              if (disc_q == msq_pkg::DISC_FIFO) begin
                tail_d = ring_next(tail_q);
              end
            end
          end else if (count_q == '0) begin
            res_st_d = msq_pkg::ST_EMPTY;
          end else if (disc_q == msq_pkg::DISC_PRIO) begin
            idx_d   = '0;
            pend_d  = 1'b0;
            state_d = S_SCAN;
          end else begin
            state_d = S_READ;
          end
        end
      end

      // stack or FIFO: the read was issued on the accept edge
      S_READ: begin
        res_val_d = rd_val;
        count_d   = count_dec;
        rem_tot_d = rem_tot_q + 32'd1;
        if (disc_q == msq_pkg::DISC_FIFO) begin
          head_d = ring_next(head_q);
        end
        state_d = S_DONE;
      end

      // find the lowest priority, one entry per cycle
      S_SCAN: begin
        rd_addr = idx_q[AW-1:0];
        if (pend_q && (pidx_q == '0 || pr_less)) begin
          best_idx_d = pidx_q;
          best_pr_d  = rd_pr;
          best_val_d = rd_val;
        end
        if (idx_q < count_q) begin
          pend_d = 1'b1;
          pidx_d = idx_q[AW-1:0];
          idx_d  = idx_q + CW'(1);
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            idx_d   = CW'(best_idx_q) + CW'(1);
            state_d = S_SHIFT;
          end
        end
      end

      // move every later entry down one slot
      S_SHIFT: begin
        rd_addr = idx_q[AW-1:0];
        if (pend_q) begin
          wr_en   = 1'b1;
          wr_addr = pidx_q - AW'(1);
          wr_data = rd_data;
        end
        if (idx_q < count_q) begin
          pend_d = 1'b1;
          pidx_d = idx_q[AW-1:0];
          idx_d  = idx_q + CW'(1);
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            res_val_d = best_val_q;
            count_d   = count_dec;
            rem_tot_d = rem_tot_q + 32'd1;
            state_d   = S_DONE;
          end
        end
      end

      // hand the result to the output register once it is free
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_val_d   = res_val_q;
          out_st_d    = res_st_q;
          out_occ_d   = count_q;
          out_peak_d  = peak_q;
          out_ins_d   = ins_tot_q;
          out_rem_d   = rem_tot_q;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      disc_q      <= msq_pkg::DISC_STACK;
      count_q     <= '0;
      peak_q      <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      ins_tot_q   <= '0;
      rem_tot_q   <= '0;
      idx_q       <= '0;
      pidx_q      <= '0;
      pend_q      <= 1'b0;
      best_idx_q  <= '0;
      best_pr_q   <= '0;
      best_val_q  <= '0;
      res_val_q   <= '0;
      res_st_q    <= msq_pkg::ST_OK;
      out_valid_q <= 1'b0;
      out_val_q   <= '0;
      out_st_q    <= msq_pkg::ST_OK;
      out_occ_q   <= '0;
      out_peak_q  <= '0;
      out_ins_q   <= '0;
      out_rem_q   <= '0;
    end else begin
      state_q     <= state_d;
      disc_q      <= disc_d;
      count_q     <= count_d;
      peak_q      <= peak_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      ins_tot_q   <= ins_tot_d;
      rem_tot_q   <= rem_tot_d;
      idx_q       <= idx_d;
      pidx_q      <= pidx_d;
      pend_q      <= pend_d;
      best_idx_q  <= best_idx_d;
      best_pr_q   <= best_pr_d;
      best_val_q  <= best_val_d;
      res_val_q   <= res_val_d;
      res_st_q    <= res_st_d;
      out_valid_q <= out_valid_d;
      out_val_q   <= out_val_d;
      out_st_q    <= out_st_d;
      out_occ_q   <= out_occ_d;
      out_peak_q  <= out_peak_d;
      out_ins_q   <= out_ins_d;
      out_rem_q   <= out_rem_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign removed_value_o  = out_val_q;
  assign status_o         = out_st_q;
  assign occupancy_o      = out_occ_q;
  assign peak_occupancy_o = out_peak_q;
  assign insert_total_o   = out_ins_q;
  assign remove_total_o   = out_rem_q;

endmodule

`default_nettype wire

[design/msq_checker.sv]
// Port-level checks for the mode-select store, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module msq_checker #(
  parameter int CAPACITY      = 1024,
  parameter int VALUE_BITS    = 32,
  parameter int PRIORITY_BITS = 16,
  localparam int CW           = $clog2(CAPACITY + 1)
) (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            cfg_we_i,
  input wire logic [1:0]                      cfg_wdata_i,
  input wire logic                            in_valid_i,
  input wire logic                            in_ready_o,
  input wire logic                            command_i,
  input wire logic [VALUE_BITS-1:0]           value_i,
  input wire logic signed [PRIORITY_BITS-1:0] priority_req_i,
  input wire logic                            out_valid_o,
  input wire logic                            out_ready_i,
  input wire logic [VALUE_BITS-1:0]           removed_value_o,
  input wire logic [1:0]                      status_o,
  input wire logic [CW-1:0]                   occupancy_o,
  input wire logic [CW-1:0]                   peak_occupancy_o,
  input wire logic [31:0]                     insert_total_o,
  input wire logic [31:0]                     remove_total_o
);

  // busy in the cycle after taking a transaction
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while a transaction is in progress");

  // a rejected remove reports an empty store and no value
  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == msq_pkg::ST_EMPTY |->
      occupancy_o == '0 && removed_value_o == '0)
    else $error("empty status with data or occupancy");

  // a rejected insert reports a full store
  a_full_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == msq_pkg::ST_FULL |->
      occupancy_o == CW'(CAPACITY) && removed_value_o == '0)
    else $error("full status without a full store");

  // peak never below occupancy, and occupancy never above capacity
  a_peak_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> occupancy_o <= peak_occupancy_o && peak_occupancy_o <= CW'(CAPACITY))
    else $error("occupancy exceeds peak or capacity");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(removed_value_o) && $stable(status_o) &&
      $stable(occupancy_o) && $stable(remove_total_o))
    else $error("stalled result changed");

endmodule

bind mode_select_stack_queue_prio msq_checker #(
  .CAPACITY      (CAPACITY),
  .VALUE_BITS    (VALUE_BITS),
  .PRIORITY_BITS (PRIORITY_BITS)
) u_msq_checker (.*);

`default_nettype wire
